// File: hdl/vhbcs_pkg.sv
// ----------------------------------------------------------------------------
// vhbcs_pkg
// shared types, constants and codes of the voxel hash best color store
// ----------------------------------------------------------------------------
package vhbcs_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int PROBE_LIMIT = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    localparam logic [31:0] INV_VOXEL_RESET = 32'd655360;

    // op codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // status codes
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_REPLACE = 3'd1;
    localparam logic [2:0] ST_KEPT    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_VALID   = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_READ_RD,
        S_READ_CHK,
        S_OUT
    } state_t;

    // table entry payload
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] color;
        logic [15:0] score;
    } entry_t;

endpackage

// File: hdl/vhbcs_mul.sv
// ----------------------------------------------------------------------------
// vhbcs_mul
// shared registered 33x33 signed multiplier
// ----------------------------------------------------------------------------
module vhbcs_mul
    import vhbcs_pkg::*;
(
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p_reg
);

    // one product per cycle, registered
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

// File: hdl/voxel_hash_best_color_store.sv
// ----------------------------------------------------------------------------
// voxel_hash_best_color_store
// spatial hash store that keeps the best scored color per voxel
// ----------------------------------------------------------------------------
// Input beats on s_axis carry an op: insert (op 0) or slot read (op 1).
// Insert scales x, y, z by inv_voxel_size to cell indices and hashes them
// with three primes; the 64-bit key is probed linearly over up to eight slots
// of a 4096-entry table. One result beat per input beat leaves on m_axis.
// A single shared multiplier does the three scale and three hash products
// one after another, then each probe is a registered table read plus a
// check. A slot read is one registered table read plus a check.
// The block takes one item at a time; s_axis_tready is low while an item is
// in work and while the result waits on m_axis, and returns the cycle after
// the result is taken. A stalled receiver holds the result beat stable.
// Reset clears the entry count and sets the register to 10.0; then a
// pass over all 4096 slots clears the valid memory, with s_axis_tready low.
// ----------------------------------------------------------------------------
module voxel_hash_best_color_store
    import vhbcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[0], pos_x[32:1], pos_y[64:33], pos_z[96:65], color[128:97],
    // score[144:129], read_slot[156:145], zero fill to 160
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], slot[14:3], entry_x[46:15], entry_y[78:47],
    // entry_z[110:79], entry_color[142:111], entry_score[158:143],
    // occupied[171:159], zero fill to 176
    output logic [175:0] m_axis_tdata
);

    state_t state_reg, state_next;

    logic [31:0]        inv_reg;
    logic [31:0]        px_reg, py_reg, pz_reg, col_reg;
    logic [15:0]        sc_reg;
    logic [SLOT_W-1:0]  rs_reg;
    logic [1:0]         idx_reg;
    logic               ph_reg;
    logic [63:0]        key_reg;
    logic [31:0]        cell_reg [3];
    logic [SLOT_W-1:0]  home_reg, cur_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               vrd_reg;
    entry_t             rd_reg;
    entry_t             mem [TABLE_DEPTH];
    logic               vmem [TABLE_DEPTH];
    logic [175:0]       out_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [31:0]        sel_pos;

    vhbcs_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p_reg(prod));

    // multiplier operand selection
    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_pos = px_reg;
            2'd1:    sel_pos = py_reg;
            default: sel_pos = pz_reg;
        endcase
        if (state_reg == S_SCALE) begin
            mul_a = {sel_pos[31], sel_pos};
            mul_b = {1'b0, inv_reg};
        end else begin
            mul_a = {cell_reg[idx_reg][31], cell_reg[idx_reg]};
            unique case (idx_reg)
                2'd0:    mul_b = {1'b0, HASH_PX};
                2'd1:    mul_b = {1'b0, HASH_PY};
                default: mul_b = {1'b0, HASH_PZ};
            endcase
        end
    end

    // probe check
    logic   is_empty, is_match, better, last_probe, tbl_wr;
    logic [63:0] key_mix;
    entry_t wr_ent;
    assign is_empty   = !vrd_reg;
    assign is_match   = vrd_reg && (rd_reg.key == key_reg);
    assign better     = sc_reg > rd_reg.score;
    assign last_probe = probe_reg == PROBE_W'(PROBE_LIMIT - 1);
    assign tbl_wr     = state_reg == S_PROBE_CHK && (is_empty || (is_match && better));
    // sign extended cell times prime, low 64 bits, folded into the key
    assign key_mix    = key_reg ^ prod[63:0];
    assign wr_ent     = '{key: key_reg, x: px_reg, y: py_reg, z: pz_reg,
                          color: col_reg, score: sc_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (cur_reg == '1) state_next = S_IDLE;
            S_IDLE:      if (s_axis_tvalid)
                             state_next = (s_axis_tdata[0] == OP_READ) ? S_READ_RD : S_SCALE;
            S_SCALE:     if (ph_reg && idx_reg == 2'd2) state_next = S_HASH;
            S_HASH:      if (ph_reg && idx_reg == 2'd2) state_next = S_PROBE_RD;
            S_PROBE_RD:  state_next = S_PROBE_CHK;
            S_PROBE_CHK: state_next = (is_empty || is_match || last_probe) ? S_OUT : S_PROBE_RD;
            S_READ_RD:   state_next = S_READ_CHK;
            S_READ_CHK:  state_next = S_OUT;
            S_OUT:       if (m_axis_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = state_reg == S_IDLE;
        m_axis_tvalid = state_reg == S_OUT;
        m_axis_tdata  = out_reg;
    end

    // table memory and valid memory
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            mem[cur_reg] <= wr_ent;
        end
        if (state_reg == S_CLEAR) begin
            vmem[cur_reg] <= 1'b0;
        end else if (tbl_wr) begin
            vmem[cur_reg] <= 1'b1;
        end
        rd_reg  <= mem[cur_reg];
        vrd_reg <= vmem[cur_reg];
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            inv_reg   <= INV_VOXEL_RESET;
            count_reg <= '0;
            cur_reg   <= '0;
            idx_reg   <= '0;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) inv_reg <= cfg_wr_data;
            unique case (state_reg)
                S_CLEAR: begin
                    cur_reg <= cur_reg + 1'b1;
                end
                S_IDLE: begin
                    px_reg  <= s_axis_tdata[32:1];
                    py_reg  <= s_axis_tdata[64:33];
                    pz_reg  <= s_axis_tdata[96:65];
                    col_reg <= s_axis_tdata[128:97];
                    sc_reg  <= s_axis_tdata[144:129];
                    rs_reg  <= s_axis_tdata[145 +: SLOT_W];
                    cur_reg <= s_axis_tdata[145 +: SLOT_W];
                    idx_reg <= '0;
                    ph_reg  <= 1'b0;
                    key_reg <= '0;
                end
                S_SCALE: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        // floor of the Q32.32 product
                        cell_reg[idx_reg] <= prod[63:32];
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                end
                S_HASH: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        key_reg <= key_mix;
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                        if (idx_reg == 2'd2) begin
                            // home slot from the finished key
                            probe_reg <= '0;
                            home_reg  <= key_mix[SLOT_W-1:0];
                            cur_reg   <= key_mix[SLOT_W-1:0];
                        end
                    end
                end
                S_PROBE_RD: ;
                S_PROBE_CHK: begin
                    if (is_empty) begin
                        count_reg <= count_reg + 1'b1;
                        out_reg <= {4'd0, 13'(count_reg + 1'b1), wr_ent.score, wr_ent.color,
                                    wr_ent.z, wr_ent.y, wr_ent.x, 12'(cur_reg), ST_NEW};
                    end else if (is_match && better) begin
                        out_reg <= {4'd0, 13'(count_reg), wr_ent.score, wr_ent.color,
                                    wr_ent.z, wr_ent.y, wr_ent.x, 12'(cur_reg), ST_REPLACE};
                    end else if (is_match) begin
                        out_reg <= {4'd0, 13'(count_reg), rd_reg.score, rd_reg.color,
                                    rd_reg.z, rd_reg.y, rd_reg.x, 12'(cur_reg), ST_KEPT};
                    end else if (last_probe) begin
                        out_reg <= {4'd0, 13'(count_reg), 144'd0, 12'(home_reg), ST_FULL};
                    end else begin
                        cur_reg   <= cur_reg + 1'b1;
                        probe_reg <= probe_reg + 1'b1;
                    end
                end
                S_READ_RD: ;
                S_READ_CHK: begin
                    if (vrd_reg)
                        out_reg <= {4'd0, 13'(count_reg), rd_reg.score, rd_reg.color,
                                    rd_reg.z, rd_reg.y, rd_reg.x, 12'(rs_reg), ST_VALID};
                    else
                        out_reg <= {4'd0, 13'(count_reg), 144'd0, 12'(rs_reg), ST_EMPTY};
                end
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/vhbcs_checker.sv
// ----------------------------------------------------------------------------
// vhbcs_checker
// port level checks of the voxel hash best color store
// ----------------------------------------------------------------------------
module vhbcs_checker
    import vhbcs_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata
);

    // held result stays stable
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no input while a result is pending
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("ready while result pending");

    // accept never yields a result in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    // status code in range
    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_EMPTY)
        else $error("bad status code");

endmodule

bind voxel_hash_best_color_store vhbcs_checker u_chk (.*);
